// File: design/signed_integer_to_text_any_base_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to text converter
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_TEXT_ANY_BASE_DEFINES_SVH
`define SIGNED_INTEGER_TO_TEXT_ANY_BASE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SITOA_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define SITOA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Types, microcode fields and constants of the integer to text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  // Microcode step address
  typedef logic [2:0] step_t;

  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_DIV   = 3'd1;
  localparam step_t STEP_STORE = 3'd2;
  localparam step_t STEP_SIGN  = 3'd3;
  localparam step_t STEP_READ  = 3'd4;
  localparam step_t STEP_EMIT  = 3'd5;
  localparam step_t STEP_BACK  = 3'd6;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_STORE,
    OP_SIGN,
    OP_READ,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CHUNK_MORE,
    COND_MORE_DIGITS,
    COND_NOT_NEG,
    COND_COUNT_NZ
  } cond_t;

  // One control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
  } ucode_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic hold;
    logic in_valid;
    logic chunk_more;
    logic more_digits;
    logic neg;
    logic count_nz;
  } status_t;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam int unsigned DIV_BITS   = 8;
  localparam logic [6:0] CHAR_MINUS  = 7'h2d;
  localparam logic [6:0] CHAR_ZERO   = 7'h30;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;

  // Digit value to ASCII: 0-9 then a-z
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_LOWER_A + {1'b0, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

// File: design/signed_integer_to_text_any_base.sv
// ----------------------------------------------------------------------------
// signed_integer_to_text_any_base
// Signed integer to ASCII text in a base from 2 to 36, microcoded.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per number, in_tdata[VALUE_WIDTH-1:0] two's complement.
//   out_* : one item per character, out_tdata[6:0] ASCII, out_tlast on the
//           final character. Negative numbers start with '-'; zero gives "0".
//   cfg_* : cfg_we writes cfg_wdata into the radix; 0/1 act as 2, above 36
//           act as 36. Write only while the block is idle.
// Timing: a small program steps through the control store. After the load
//   step, each digit takes one division step per 8-bit chunk of the value
//   (the shared divider resolves 8 quotient bits a cycle) and a store step;
//   then each digit is emitted by a memory read step and an output register
//   step, after one sign step and before one step to return. The sign leaves
//   after the last digit is stored, and each digit after its memory read.
//   One number is converted at a time.
// Reset: radix returns to 10, the program to its wait step, output empty.
// Stall: a held out_tready freezes the program at the sign or emit step; the
//   waiting character stays stable in the output register.
// ----------------------------------------------------------------------------
module signed_integer_to_text_any_base #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // tdata: number[VALUE_WIDTH-1:0], zero padding above
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       in_tdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata: text_char[6:0], zero bit 7
  output logic [7:0]                             out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_we,
  input  logic [5:0]                             cfg_wdata
);
  import sitoa_pkg::*;

  step_t   step_r;
  step_t   step_nxt;
  ucode_t  uc;
  status_t st;
  logic    cond_true;
  logic [6:0] out_char;

  sitoa_ucode_rom u_rom (
    .step (step_r),
    .uc   (uc)
  );

  sitoa_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .uc        (uc),
    .in_valid  (in_tvalid),
    .in_number (in_tdata[VALUE_WIDTH-1:0]),
    .in_ready  (in_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (st),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

  // Jump condition decode
  always_comb begin
    unique case (uc.cond)
      COND_NEVER:       cond_true = 1'b0;
      COND_ALWAYS:      cond_true = 1'b1;
      COND_NO_INPUT:    cond_true = !st.in_valid;
      COND_CHUNK_MORE:  cond_true = st.chunk_more;
      COND_MORE_DIGITS: cond_true = st.more_digits;
      COND_NOT_NEG:     cond_true = !st.neg;
      COND_COUNT_NZ:    cond_true = st.count_nz;
      default:          cond_true = 1'b1;
    endcase
  end

  // Step counter: hold on stall, jump when taken, else advance
  always_comb begin
    if (st.hold) begin
      step_nxt = step_r;
    end else if (cond_true) begin
      step_nxt = uc.jump;
    end else begin
      step_nxt = step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: design/sitoa_ucode_rom.sv
// ----------------------------------------------------------------------------
// sitoa_ucode_rom
// Control store: one control word per step of the conversion program.
// ----------------------------------------------------------------------------
module sitoa_ucode_rom (
  input  sitoa_pkg::step_t  step,
  output sitoa_pkg::ucode_t uc
);
  import sitoa_pkg::*;

  // Program: load, divide digit by digit, optional sign, emit digits
  always_comb begin
    unique case (step)
      STEP_WAIT:  uc = '{op: OP_LOAD,  cond: COND_NO_INPUT,    jump: STEP_WAIT};
      STEP_DIV:   uc = '{op: OP_DIV,   cond: COND_CHUNK_MORE,  jump: STEP_DIV};
      STEP_STORE: uc = '{op: OP_STORE, cond: COND_MORE_DIGITS, jump: STEP_DIV};
      STEP_SIGN:  uc = '{op: OP_SIGN,  cond: COND_NEVER,       jump: STEP_WAIT};
      STEP_READ:  uc = '{op: OP_READ,  cond: COND_NEVER,       jump: STEP_WAIT};
      STEP_EMIT:  uc = '{op: OP_EMIT,  cond: COND_COUNT_NZ,    jump: STEP_READ};
      STEP_BACK:  uc = '{op: OP_NOP,   cond: COND_ALWAYS,      jump: STEP_WAIT};
      default:    uc = '{op: OP_NOP,   cond: COND_ALWAYS,      jump: STEP_WAIT};
    endcase
  end

endmodule

// File: design/sitoa_datapath.sv
// ----------------------------------------------------------------------------
// sitoa_datapath
// Radix register, shared digit divider, digit memory and output register,
// all driven by the current control word.
// ----------------------------------------------------------------------------
module sitoa_datapath #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sitoa_pkg::ucode_t        uc,
  input  logic                     in_valid,
  input  logic [VALUE_WIDTH-1:0]   in_number,
  output logic                     in_ready,
  input  logic                     cfg_we,
  input  logic [5:0]               cfg_wdata,
  output sitoa_pkg::status_t       status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [6:0]               out_char,
  output logic                     out_last
);
  import sitoa_pkg::*;

  localparam int STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int QW    = STEPS * DIV_BITS;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int AW    = $clog2(MAX_DIGITS);

  logic [5:0]       radix_r;
  logic [5:0]       base;
  logic [QW-1:0]    q_r;
  logic [QW-1:0]    q_div;
  logic [5:0]       rem_r;
  logic [5:0]       rem_div;
  logic [CW-1:0]    chunk_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_m1;
  logic             neg_r;
  logic [5:0]       rd_data_r;
  logic [5:0]       mem [MAX_DIGITS];
  logic             out_valid_r;
  logic [6:0]       out_char_r;
  logic             out_last_r;
  logic             out_free;
  logic             emit_sign;
  logic             emit_digit;
  logic             hold;
  logic             load;
  logic [VALUE_WIDTH-1:0] mag;

  // Radix register, saturated to 2..36 for use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  assign base = (radix_r < RADIX_MIN) ? RADIX_MIN :
                (radix_r > RADIX_MAX) ? RADIX_MAX : radix_r;

  // Handshake and stall decisions
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (uc.op == OP_LOAD);
  assign load       = in_ready && in_valid;
  assign emit_sign  = (uc.op == OP_SIGN) && neg_r;
  assign emit_digit = (uc.op == OP_EMIT);
  assign hold       = (emit_sign || emit_digit) && !out_free;

  assign status.hold        = hold;
  assign status.in_valid    = in_valid;
  assign status.chunk_more  = (chunk_r != CW'(STEPS - 1));
  assign status.more_digits = (q_r != '0) && (count_r < CNT_W'(MAX_DIGITS - 1));
  assign status.neg         = neg_r;
  assign status.count_nz    = (count_r != '0);

  // Magnitude of the input; the most negative value maps to its unsigned size
  assign mag = in_number[VALUE_WIDTH-1] ? (~in_number + VALUE_WIDTH'(1)) : in_number;

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [6:0] t;
    logic [5:0] r;
    logic [DIV_BITS-1:0] qb;
    r  = rem_r;
    qb = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, q_r[QW-1-i]};
      if (t >= {1'b0, base}) begin
        r  = 6'(t - {1'b0, base});
        qb[DIV_BITS-1-i] = 1'b1;
      end else begin
        r  = t[5:0];
      end
    end
    rem_div = r;
    q_div   = (q_r << DIV_BITS) | QW'(qb);
  end

  assign count_m1 = count_r - CNT_W'(1);

  // Conversion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      neg_r   <= 1'b0;
      chunk_r <= '0;
    end else begin
      case (uc.op)
        OP_LOAD: begin
          if (load) begin
            neg_r   <= in_number[VALUE_WIDTH-1];
            count_r <= '0;
            chunk_r <= '0;
          end
        end
        OP_DIV:   chunk_r <= chunk_r + CW'(1);
        OP_STORE: begin
          count_r <= count_r + CNT_W'(1);
          chunk_r <= '0;
        end
        OP_READ:  count_r <= count_m1;
        default: ;
      endcase
    end
  end

  // Quotient and remainder payload
  always_ff @(posedge clk) begin
    case (uc.op)
      OP_LOAD: begin
        q_r   <= QW'(mag);
        rem_r <= '0;
      end
      OP_DIV: begin
        q_r   <= q_div;
        rem_r <= rem_div;
      end
      OP_STORE: rem_r <= '0;
      default: ;
    endcase
  end

  // Digit memory: write on store, registered read on read step
  always_ff @(posedge clk) begin
    if (uc.op == OP_STORE) begin
      mem[count_r[AW-1:0]] <= rem_r;
    end
    if (uc.op == OP_READ) begin
      rd_data_r <= mem[count_m1[AW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((emit_sign || emit_digit) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign && out_free) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (emit_digit && out_free) begin
      out_char_r <= digit_char(rd_data_r);
      out_last_r <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// File: design/sitoa_checker.sv
// ----------------------------------------------------------------------------
// sitoa_checker
// Port-level checks of the integer to text converter, bound to the top.
// ----------------------------------------------------------------------------
`include "signed_integer_to_text_any_base_defines.svh"

module sitoa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import sitoa_pkg::*;

  // A waiting character holds until taken
  `SITOA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output item changed while stalled")

  // One number at a time: no new accept right after an accept
  `SITOA_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready,
    !in_tready, "input taken on two cycles in a row")

  // A sign is never the final character
  `SITOA_ASSERT_NOW(a_sign_not_last, clk, rst_n,
    out_tvalid && (out_tdata[6:0] == CHAR_MINUS), !out_tlast, "sign marked as last")

  // No new number while a string is still incomplete
  `SITOA_ASSERT_NOW(a_no_overlap, clk, rst_n, out_tvalid && !out_tlast,
    !in_tready, "input ready in the middle of a string")

endmodule

bind signed_integer_to_text_any_base sitoa_checker u_sitoa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: test/signed_integer_to_text_any_base_checker.sv
// ----------------------------------------------------------------------------
// Text stream checker for the integer to text converter
// Watches the radix register port, the number channel and the character
// channel. Each accepted number is turned into its expected characters, and
// every accepted character is compared with the oldest one still expected.
// ----------------------------------------------------------------------------
module signed_integer_to_text_checker
  import sitoa_pkg::RADIX_RESET, sitoa_pkg::RADIX_MIN, sitoa_pkg::RADIX_MAX,
         sitoa_pkg::CHAR_MINUS;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  output int          fail_count,
  output int          pending_chars
);

  // One expected character item
  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } text_item_t;

  text_item_t expected_text[$];
  logic [5:0] radix_copy;

  // Convert one number into the character items it should produce
  function automatic void predict_text(input logic [31:0] number);
    logic [31:0] base;
    logic [31:0] magnitude;
    logic [5:0]  digits [32];
    logic [6:0]  symbol;
    logic        negative;
    int          count;
    text_item_t  item;
    base = {26'd0, radix_copy};
    if (radix_copy < RADIX_MIN) base = {26'd0, RADIX_MIN};
    if (radix_copy > RADIX_MAX) base = {26'd0, RADIX_MAX};
    negative  = number[31];
    // the most negative value maps onto its exact unsigned magnitude
    magnitude = negative ? (~number + 32'd1) : number;
    count = 0;
    do begin
      digits[count] = 6'(magnitude % base);
      magnitude     = magnitude / base;
      count++;
    end while (magnitude != 0 && count < 32);
    if (negative) begin
      item.text_char = CHAR_MINUS;
      item.last_char = 1'b0;
      expected_text.push_back(item);
    end
    for (int i = count - 1; i >= 0; i--) begin
      if (digits[i] < 6'd10) begin
        symbol = 7'h30 + {1'b0, digits[i]};
      end else begin
        symbol = 7'h57 + {1'b0, digits[i]};
      end
      item.text_char = symbol;
      item.last_char = (i == 0);
      expected_text.push_back(item);
    end
  endfunction

  // Track the register, predict on each number, compare each character
  always @(posedge clk) begin
    text_item_t want;
    if (!rst_n) begin
      radix_copy    <= RADIX_RESET;
      fail_count    <= 0;
      pending_chars <= 0;
      expected_text.delete();
    end else begin
      if (cfg_we) begin
        radix_copy <= cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character item: text_char %h last_char %b",
                 out_tdata[6:0], out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_text.pop_front();
          if (out_tdata[6:0] !== want.text_char || out_tlast !== want.last_char) begin
            if (out_tdata[6:0] !== want.text_char) begin
              $error("text_char: expected %h, got %h", want.text_char, out_tdata[6:0]);
            end
            if (out_tlast !== want.last_char) begin
              $error("last_char: expected %b, got %b", want.last_char, out_tlast);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
      end
      pending_chars <= expected_text.size();
    end
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the integer to text converter
// Drives numbers through a set of radix settings, including the saturating
// ones, with random gaps on both channels; a checker instance predicts and
// compares the character stream and reports its failure count here.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst_n;
  logic [31:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;
  int          fail_count;
  int          pending_chars;
  int          in_idle_pct;
  int          out_idle_pct;
  logic [5:0]  radix_now;

  signed_integer_to_text_any_base #(
    .VALUE_WIDTH(32),
    .MAX_DIGITS (32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  signed_integer_to_text_checker text_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_chars(pending_chars)
  );

  // Clock, period 12
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Run limit
  initial begin
    #12000000;
    $display("FAILURE");
    $finish;
  end

  // Offer one number item, with random idle cycles before it
  task automatic send_number(input logic [31:0] number);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= number;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Let every expected character come out, then let the block settle
  task automatic drain_text();
    in_tvalid <= 1'b0;
    while (pending_chars != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Register write while idle
  task automatic write_radix(input logic [5:0] value);
    drain_text();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    radix_now  = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random number: full range, short values, extremes, powers of the base
  function automatic logic [31:0] random_number(input logic [5:0] radix);
    logic [63:0] power;
    logic [31:0] value;
    int unsigned base;
    int unsigned steps;
    base = radix < 6'd2 ? 2 : (radix > 6'd36 ? 36 : radix);
    case ($urandom_range(0, 5))
      0: value = $urandom_range(0, 99);
      1: begin
        case ($urandom_range(0, 4))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = 32'h0000_0000;
          3: value = 32'h0000_0001;
          default: value = 32'hffff_ffff;
        endcase
      end
      2: begin
        power = 64'd1;
        steps = $urandom_range(1, 31);
        for (int j = 0; j < steps; j++) begin
          if (power * base <= 64'h7fff_ffff) power = power * base;
        end
        value = power[31:0] + $urandom_range(0, 2) - 32'd1;
      end
      3: value = $urandom >> $urandom_range(0, 31);
      default: value = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1) value = ~value + 32'd1;
    return value;
  endfunction

  // Stimulus and verdict
  initial begin
    logic [5:0] segment_radix [10];
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    radix_now    = 6'd10;
    in_idle_pct  = 34;
    out_idle_pct = 78;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset radix, then the narrowest and widest bases
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hffff_ffff);
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    send_number(32'd9);
    send_number(32'hffff_fff6);
    write_radix(6'd2);
    send_number(32'h8000_0000);
    send_number(32'h7fff_ffff);
    send_number(32'd0);
    send_number(32'hffff_ffff);
    send_number(32'd5);
    write_radix(6'd36);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'h8000_0000);
    send_number(32'h7fff_ffff);
    // Saturating radix values on both sides
    write_radix(6'd0);
    send_number(32'd6);
    write_radix(6'd1);
    send_number(32'hffff_fff9);
    write_radix(6'd37);
    send_number(32'd71);
    write_radix(6'd63);
    send_number(32'hffff_faf1);
    send_number(32'd1296);

    // Random part, one radix per segment
    segment_radix = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd10, 6'd16, 6'd1, 6'd37,
                      6'd0, 6'd0};
    segment_radix[8] = 6'($urandom_range(0, 63));
    segment_radix[9] = 6'($urandom_range(2, 36));
    for (int s = 0; s < 10; s++) begin
      write_radix(segment_radix[s]);
      if (s < 3) begin
        in_idle_pct  = 34;
        out_idle_pct = 78;
      end else if (s < 6) begin
        in_idle_pct  = 78;
        out_idle_pct = 34;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      for (int n = 0; n < 37; n++) begin
        send_number(random_number(radix_now));
      end
    end

    drain_text();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
